// ===== sv/rlzt_pkg.sv =====
// rlzt_pkg: shared types and constants for the RLE/LZ token byte encoder.
// Holds the beat structs, the command codes and the internal job record.
// No dependencies.
package rlzt_pkg;

    // Command codes of an input beat
    localparam logic [2:0] CMD_LIT_HDR = 3'd0;
    localparam logic [2:0] CMD_LITERAL = 3'd1;
    localparam logic [2:0] CMD_RUN     = 3'd2;
    localparam logic [2:0] CMD_MATCH   = 3'd3;
    localparam logic [2:0] CMD_FINISH  = 3'd4;

    // Byte tags of the format
    localparam logic [7:0] TAG_LIT_LONG  = 8'h20;
    localparam logic [7:0] TAG_RUN_SHORT = 8'h40;
    localparam logic [7:0] TAG_RUN_LONG  = 8'h50;
    localparam logic [7:0] TAG_MATCH_EXT = 8'h60;
    localparam logic [7:0] TAG_MATCH     = 8'h80;

    localparam logic [12:0] LIT_SHORT_MAX  = 13'd31;
    localparam logic [12:0] RUN_SHORT_MAX  = 13'd15;
    localparam logic [12:0] MIN_LENGTH     = 13'd4;
    localparam logic [10:0] EXT_PIECE_MAX  = 11'd31;
    localparam logic [15:0] SIZE_RESET     = 16'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [12:0] run_length;
        logic [12:0] match_distance;
        logic [7:0]  byte_value;
    } token_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       size_byte;
        logic       bad_token;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        JK_BAD,
        JK_LIT_HDR,
        JK_LITERAL,
        JK_RUN,
        JK_MATCH,
        JK_FINISH
    } job_kind_t;

    // Classified token. len holds the literal length, the run extra, or
    // the match extra left after the head.
    typedef struct packed {
        job_kind_t   kind;
        logic        long_form;
        logic [1:0]  head_extra;
        logic [12:0] len;
        logic [12:0] distance;
        logic [7:0]  val;
    } job_t;

    typedef enum logic [1:0] {
        PH_B0,
        PH_B1,
        PH_B2
    } phase_t;

endpackage

// ===== sv/rle_lz_token_byte_encoder_top.sv =====
// Top level of the RLE/LZ token byte encoder.
// Depends on rlzt_pkg, rlzt_front, rlzt_queue and rlzt_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one token per beat:
//   literal-run header, literal byte, run, dictionary match or finish.
//   Output channel (out_valid/out_ready/out_data) carries one encoded byte
//   per beat; last marks the final beat caused by a token. Out-of-range
//   tokens and unknown commands give a single beat with bad_token set.
//   Finish gives the two stream-size bytes (size_byte set), low byte
//   first; the size counts them plus every token byte since reset or the
//   previous finish, modulo 65536.
// Flow and throughput:
//   A token is classified as it is taken and lands in a two-entry queue;
//   its first byte reaches out_valid through the queue entry and then
//   the output register. The sequencer emits one byte per cycle while
//   out_ready holds it not; most tokens have 1 to 3 bytes, the longest
//   match 63. That single byte port sets the sustained rate.
// Reset and stalls:
//   rst_n (async, active low) empties the queue and output register and
//   sets the size count to 2. When out_ready is low the output register
//   holds its beat; the queue keeps taking tokens until both entries fill.
module rle_lz_token_byte_encoder_top #(
    parameter int MAX_MATCH_LENGTH = 1898,
    parameter int MAX_LITERAL_RUN  = 8191,
    parameter int MAX_RUN_EXTRA    = 4095
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rlzt_pkg::token_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rlzt_pkg::result_t out_data
);

    logic           push;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    rlzt_pkg::job_t push_job;
    rlzt_pkg::job_t head_job;

    // Classifier: range checks and length arithmetic per token
    rlzt_front #(
        .MAX_MATCH_LENGTH (MAX_MATCH_LENGTH),
        .MAX_LITERAL_RUN  (MAX_LITERAL_RUN),
        .MAX_RUN_EXTRA    (MAX_RUN_EXTRA)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Decouples token intake from byte output
    rlzt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Byte sequencer with registered output and stream size count
    rlzt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== sv/rlzt_front.sv =====
// rlzt_front: accepts input beats, range-checks and classifies each token.
// Depends on rlzt_pkg; feeds rlzt_queue.
module rlzt_front #(
    parameter int MAX_MATCH_LENGTH = 1898,
    parameter int MAX_LITERAL_RUN  = 8191,
    parameter int MAX_RUN_EXTRA    = 4095
) (
    input  logic             in_valid,
    output logic             in_ready,
    input  rlzt_pkg::token_t in_data,
    input  logic             queue_full,
    output logic             push,
    output rlzt_pkg::job_t   push_job
);

    localparam logic [12:0] LitMax   = 13'(MAX_LITERAL_RUN);
    localparam logic [12:0] RunMax   = 13'(MAX_RUN_EXTRA + 4);
    localparam logic [12:0] MatchMax = 13'(MAX_MATCH_LENGTH);

    logic [12:0] extra;
    logic [1:0]  head;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign extra = in_data.run_length - rlzt_pkg::MIN_LENGTH;
    assign head  = (extra > 13'd3) ? 2'd3 : extra[1:0];

    always_comb
    begin
        push_job.kind       = rlzt_pkg::JK_BAD;
        push_job.long_form  = 1'b0;
        push_job.head_extra = head;
        push_job.len        = in_data.run_length;
        push_job.distance   = in_data.match_distance;
        push_job.val        = in_data.byte_value;
        unique case (in_data.command)
            rlzt_pkg::CMD_LIT_HDR:
            begin
                if (in_data.run_length != 13'd0 && in_data.run_length <= LitMax)
                    push_job.kind = rlzt_pkg::JK_LIT_HDR;
                push_job.long_form = in_data.run_length > rlzt_pkg::LIT_SHORT_MAX;
            end
            rlzt_pkg::CMD_LITERAL:
                push_job.kind = rlzt_pkg::JK_LITERAL;
            rlzt_pkg::CMD_RUN:
            begin
                if (in_data.run_length >= rlzt_pkg::MIN_LENGTH && in_data.run_length <= RunMax)
                    push_job.kind = rlzt_pkg::JK_RUN;
                push_job.long_form = extra > rlzt_pkg::RUN_SHORT_MAX;
                push_job.len       = extra;
            end
            rlzt_pkg::CMD_MATCH:
            begin
                if (in_data.run_length >= rlzt_pkg::MIN_LENGTH
                    && in_data.run_length <= MatchMax
                    && in_data.match_distance != 13'd0)
                    push_job.kind = rlzt_pkg::JK_MATCH;
                push_job.len = extra - {11'd0, head};
            end
            rlzt_pkg::CMD_FINISH:
                push_job.kind = rlzt_pkg::JK_FINISH;
            default:
                push_job.kind = rlzt_pkg::JK_BAD;
        endcase
    end

endmodule

// ===== sv/rlzt_queue.sv =====
// rlzt_queue: two-entry job queue between the classifier and the sequencer.
// Depends on rlzt_pkg.
module rlzt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rlzt_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rlzt_pkg::job_t head_job
);

    rlzt_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/rlzt_back.sv =====
// rlzt_back: byte sequencer; turns queued jobs into result beats, one per
// cycle unless out_ready stalls it, through an output register. Keeps the
// running stream size. Depends on rlzt_pkg.
module rlzt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  rlzt_pkg::job_t    head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output rlzt_pkg::result_t out_data
);

    rlzt_pkg::phase_t  phase_reg, phase_next;
    logic [10:0]       rem_reg, rem_next;
    logic [15:0]       size_reg, size_next;
    rlzt_pkg::result_t out_reg;
    logic              out_valid_reg;

    rlzt_pkg::result_t res;
    logic              advance;
    logic [4:0]        piece;

    assign advance   = head_valid && (!out_valid_reg || out_ready);
    assign pop       = advance && res.last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign piece     = (rem_reg > rlzt_pkg::EXT_PIECE_MAX) ? 5'd31 : rem_reg[4:0];

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            if (res.last)
                phase_next = rlzt_pkg::PH_B0;
            else
            begin
                unique case (phase_reg)
                    rlzt_pkg::PH_B0: phase_next = rlzt_pkg::PH_B1;
                    rlzt_pkg::PH_B1: phase_next = rlzt_pkg::PH_B2;
                    rlzt_pkg::PH_B2: phase_next = rlzt_pkg::PH_B2;
                    default:         phase_next = rlzt_pkg::PH_B0;
                endcase
            end
        end
    end

    // Byte produced in the current phase
    always_comb
    begin
        res = '0;
        unique case (head_job.kind)
            rlzt_pkg::JK_LIT_HDR:
            begin
                if (head_job.long_form && phase_reg == rlzt_pkg::PH_B0)
                    res.out_byte = rlzt_pkg::TAG_LIT_LONG | {3'd0, head_job.len[12:8]};
                else
                begin
                    res.out_byte = head_job.len[7:0];
                    res.last     = 1'b1;
                end
            end
            rlzt_pkg::JK_LITERAL:
            begin
                res.out_byte = head_job.val;
                res.last     = 1'b1;
            end
            rlzt_pkg::JK_RUN:
            begin
                if (phase_reg == rlzt_pkg::PH_B0)
                    res.out_byte = head_job.long_form
                        ? (rlzt_pkg::TAG_RUN_LONG | {4'd0, head_job.len[11:8]})
                        : (rlzt_pkg::TAG_RUN_SHORT | {4'd0, head_job.len[3:0]});
                else if (phase_reg == rlzt_pkg::PH_B1 && head_job.long_form)
                    res.out_byte = head_job.len[7:0];
                else
                begin
                    res.out_byte = head_job.val;
                    res.last     = 1'b1;
                end
            end
            rlzt_pkg::JK_MATCH:
            begin
                unique case (phase_reg)
                    rlzt_pkg::PH_B0:
                        res.out_byte = rlzt_pkg::TAG_MATCH
                            | {1'b0, head_job.head_extra, head_job.distance[12:8]};
                    rlzt_pkg::PH_B1:
                    begin
                        res.out_byte = head_job.distance[7:0];
                        res.last     = head_job.len == 13'd0;
                    end
                    default:
                    begin
                        res.out_byte = rlzt_pkg::TAG_MATCH_EXT | {3'd0, piece};
                        res.last     = rem_reg <= rlzt_pkg::EXT_PIECE_MAX;
                    end
                endcase
            end
            rlzt_pkg::JK_FINISH:
            begin
                res.size_byte = 1'b1;
                if (phase_reg == rlzt_pkg::PH_B0)
                    res.out_byte = size_reg[7:0];
                else
                begin
                    res.out_byte = size_reg[15:8];
                    res.last     = 1'b1;
                end
            end
            default:
            begin
                res.bad_token = 1'b1;
                res.last      = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rem_next  = rem_reg;
        size_next = size_reg;
        if (advance)
        begin
            if (head_job.kind == rlzt_pkg::JK_MATCH)
            begin
                if (phase_reg == rlzt_pkg::PH_B1)
                    rem_next = head_job.len[10:0];
                else if (phase_reg == rlzt_pkg::PH_B2)
                    rem_next = rem_reg - {6'd0, piece};
            end
            if (head_job.kind == rlzt_pkg::JK_FINISH && res.last)
                size_next = rlzt_pkg::SIZE_RESET;
            else if (!res.bad_token && !res.size_byte)
                size_next = size_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rlzt_pkg::PH_B0;
            rem_reg       <= 11'd0;
            size_reg      <= rlzt_pkg::SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            size_reg  <= size_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop without a queued job");

    a_phase_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> phase_reg == rlzt_pkg::PH_B0)
        else $error("phase not restarted after job");

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.bad_token |-> out_reg.last && !out_reg.size_byte)
        else $error("error beat not single");

    a_size_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_job.kind == rlzt_pkg::JK_FINISH |=> size_reg == rlzt_pkg::SIZE_RESET)
        else $error("size counter not rewound after finish");

    a_rem_zero_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && head_job.kind == rlzt_pkg::JK_MATCH && phase_reg == rlzt_pkg::PH_B2
        |-> rem_reg != 11'd0)
        else $error("continuation byte with nothing left");

endmodule

// ===== tb/sv/rle_lz_token_byte_encoder_top_tb.sv =====
// Self-checking testbench for rle_lz_token_byte_encoder_top.
// Drives token beats, predicts every encoded byte and compares each output beat.
// Depends on rlzt_pkg and the encoder RTL.
`timescale 1ns / 100ps

module rle_lz_token_byte_encoder_top_tb;

    localparam int MAX_MATCH_LEN   = 1898;
    localparam int MAX_LIT_RUN     = 8191;
    localparam int MAX_RUN_EXT     = 4095;
    localparam int MAX_BYTES       = 63;      // bytes of the longest match
    localparam int HOLD_CYCLES     = 400;     // long receiver back-pressure
    localparam int SETTLE_CYCLES   = 12;      // margin after everything drains
    localparam int LIMIT_CYCLES    = 2000000;
    localparam int REPORT_MAX      = 10;

    // Command codes the block does not know
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    rlzt_pkg::token_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    rlzt_pkg::result_t out_data;

    rlzt_pkg::token_t  token_queue[$];      // beats not yet offered
    rlzt_pkg::result_t pending_bytes[$];    // encoded bytes still owed by the block
    logic [15:0]       stream_size;         // predicted size count, size bytes included
    rlzt_pkg::result_t oldest_byte;
    int                mismatches     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_req       = 0;
    int                hold_count     = 0;
    int                cycle_count    = 0;

    rle_lz_token_byte_encoder_top #(
        .MAX_MATCH_LENGTH (MAX_MATCH_LEN),
        .MAX_LITERAL_RUN  (MAX_LIT_RUN),
        .MAX_RUN_EXTRA    (MAX_RUN_EXT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Byte predictor
    // ------------------------------------------------------------------

    // Queue one stream byte; size bytes do not count toward the stream size.
    function automatic void add_byte(logic [7:0] b, logic is_size);
        rlzt_pkg::result_t r;
        r.out_byte  = b;
        r.size_byte = is_size;
        r.bad_token = 1'b0;
        r.last      = 1'b0;
        pending_bytes.push_back(r);
        if (!is_size)
            stream_size = stream_size + 16'd1;
    endfunction

    // Encode one accepted token into the bytes the block must produce.
    function automatic void encode_token(rlzt_pkg::token_t t);
        rlzt_pkg::result_t r;
        logic              bad;
        logic [12:0]       ext;
        logic [12:0]       head;
        logic [12:0]       rest;
        logic [12:0]       piece;
        logic [15:0]       size;
        int                count;
        bad = 1'b0;
        case (t.command)
            rlzt_pkg::CMD_LIT_HDR:
            begin
                if (t.run_length == 0 || int'(t.run_length) > MAX_LIT_RUN)
                    bad = 1'b1;
                else if (t.run_length > rlzt_pkg::LIT_SHORT_MAX)
                begin
                    add_byte(rlzt_pkg::TAG_LIT_LONG | {3'b000, t.run_length[12:8]}, 1'b0);
                    add_byte(t.run_length[7:0], 1'b0);
                end
                else
                    add_byte(t.run_length[7:0], 1'b0);
            end
            rlzt_pkg::CMD_LITERAL:
                add_byte(t.byte_value, 1'b0);
            rlzt_pkg::CMD_RUN:
            begin
                if (t.run_length < rlzt_pkg::MIN_LENGTH
                    || int'(t.run_length) > MAX_RUN_EXT + 4)
                    bad = 1'b1;
                else
                begin
                    ext = t.run_length - rlzt_pkg::MIN_LENGTH;
                    if (ext > rlzt_pkg::RUN_SHORT_MAX)
                    begin
                        add_byte(rlzt_pkg::TAG_RUN_LONG | {4'b0000, ext[11:8]}, 1'b0);
                        add_byte(ext[7:0], 1'b0);
                    end
                    else
                        add_byte(rlzt_pkg::TAG_RUN_SHORT | {4'b0000, ext[3:0]}, 1'b0);
                    add_byte(t.byte_value, 1'b0);
                end
            end
            rlzt_pkg::CMD_MATCH:
            begin
                if (t.run_length < rlzt_pkg::MIN_LENGTH || int'(t.run_length) > MAX_MATCH_LEN
                    || t.match_distance == 0)
                    bad = 1'b1;
                else
                begin
                    ext  = t.run_length - rlzt_pkg::MIN_LENGTH;
                    head = (ext > 13'd3) ? 13'd3 : ext;
                    add_byte(rlzt_pkg::TAG_MATCH
                             | {1'b0, head[1:0], t.match_distance[12:8]}, 1'b0);
                    add_byte(t.match_distance[7:0], 1'b0);
                    rest  = ext - head;
                    count = 2;
                    while (rest != 0 && count < MAX_BYTES)
                    begin
                        piece = (rest > 13'd31) ? 13'd31 : rest;
                        add_byte(rlzt_pkg::TAG_MATCH_EXT | piece[7:0], 1'b0);
                        rest  = rest - piece;
                        count = count + 1;
                    end
                end
            end
            rlzt_pkg::CMD_FINISH:
            begin
                size = stream_size;
                add_byte(size[7:0], 1'b1);
                add_byte(size[15:8], 1'b1);
                stream_size = rlzt_pkg::SIZE_RESET;
            end
            default:
                bad = 1'b1;
        endcase
        if (bad)
        begin
            r.out_byte  = 8'h00;
            r.size_byte = 1'b0;
            r.bad_token = 1'b1;
            r.last      = 1'b1;
            pending_bytes.push_back(r);
        end
        else
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic rlzt_pkg::token_t make_token(logic [2:0] cmd, int len, int distance,
                                                    int val);
        rlzt_pkg::token_t t;
        t.command        = cmd;
        t.run_length     = len[12:0];
        t.match_distance = distance[12:0];
        t.byte_value     = val[7:0];
        return t;
    endfunction

    // Mostly well-formed tokens, short lengths, now and then the long end,
    // a few out-of-range ones. Unused fields carry random noise.
    function automatic void add_random_tokens(int count);
        rlzt_pkg::token_t t;
        int               pick;
        int               n;
        int               i;
        n = 0;
        while (n < count)
        begin
            t.command        = rlzt_pkg::CMD_LITERAL;
            t.run_length     = 13'($urandom_range(0, 8191));
            t.match_distance = 13'($urandom_range(0, 8191));
            t.byte_value     = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 14)
            begin
                // literal run: header, then its bytes when short
                t.command    = rlzt_pkg::CMD_LIT_HDR;
                t.run_length = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(1, 8191))
                                                           : 13'($urandom_range(1, 6));
                token_queue.push_back(t);
                n = n + 1;
                if (t.run_length <= 6)
                    for (i = 0; i < int'(t.run_length); i++)
                    begin
                        token_queue.push_back(make_token(rlzt_pkg::CMD_LITERAL,
                            $urandom_range(0, 8191), $urandom_range(0, 8191),
                            $urandom_range(0, 255)));
                        n = n + 1;
                    end
                continue;
            end
            else if (pick < 30)
                t.command = rlzt_pkg::CMD_LITERAL;
            else if (pick < 50)
            begin
                t.command    = rlzt_pkg::CMD_RUN;
                t.run_length = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(4, 4099))
                                                           : 13'($urandom_range(4, 30));
            end
            else if (pick < 80)
            begin
                t.command        = rlzt_pkg::CMD_MATCH;
                t.match_distance = 13'($urandom_range(1, 8191));
                case ($urandom_range(0, 19))
                    0:       t.run_length = 13'(MAX_MATCH_LEN);
                    1:       t.run_length = 13'($urandom_range(4, MAX_MATCH_LEN));
                    default: t.run_length = 13'($urandom_range(4, 80));
                endcase
            end
            else if (pick < 88)
                t.command = rlzt_pkg::CMD_FINISH;
            else
            begin
                case ($urandom_range(0, 6))
                    0: t.command = CMD_RSVD5;
                    1: t.command = CMD_RSVD6;
                    2: t.command = CMD_RSVD7;
                    3:
                    begin
                        t.command    = rlzt_pkg::CMD_LIT_HDR;
                        t.run_length = 13'd0;
                    end
                    4:
                    begin
                        t.command    = rlzt_pkg::CMD_RUN;
                        t.run_length = ($urandom_range(0, 1) == 0)
                                       ? 13'($urandom_range(0, 3))
                                       : 13'($urandom_range(4100, 8191));
                    end
                    5:
                    begin
                        t.command    = rlzt_pkg::CMD_MATCH;
                        t.run_length = ($urandom_range(0, 1) == 0)
                                       ? 13'($urandom_range(0, 3))
                                       : 13'($urandom_range(1899, 8191));
                    end
                    default:
                    begin
                        t.command        = rlzt_pkg::CMD_MATCH;
                        t.run_length     = 13'($urandom_range(4, 40));
                        t.match_distance = 13'd0;
                    end
                endcase
            end
            token_queue.push_back(t);
            n = n + 1;
        end
    endfunction

    // Sender pause: nothing queued, nothing offered, nothing owed.
    task automatic wait_drained();
        while (token_queue.size() != 0 || in_valid || pending_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idle(idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 15 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 15 : 0;
    endtask

    // Fields shown as byte/size/bad/last
    task automatic flag_mismatch(string what, rlzt_pkg::result_t want,
                                 rlzt_pkg::result_t got);
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: exp %02h/%b/%b/%b, got %02h/%b/%b/%b",
                     $time, what, want.out_byte, want.size_byte, want.bad_token, want.last,
                     got.out_byte, got.size_byte, got.bad_token, got.last);
    endtask

    // ------------------------------------------------------------------
    // Input driver: holds a beat until accepted, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            stream_size = rlzt_pkg::SIZE_RESET;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_token(in_data);
            if (!in_valid || in_ready)
            begin
                if (token_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= token_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long back-pressure window, counted on its own
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_count <= hold_req;
            hold_req = 0;
        end
        else if (hold_count != 0)
            hold_count <= hold_count - 1;
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each beat against the oldest owed byte
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    oldest_byte = '0;
                    flag_mismatch("unexpected beat", oldest_byte, out_data);
                end
                else
                begin
                    oldest_byte = pending_bytes.pop_front();
                    if (out_data.out_byte  !== oldest_byte.out_byte  ||
                        out_data.size_byte !== oldest_byte.size_byte ||
                        out_data.bad_token !== oldest_byte.bad_token ||
                        out_data.last      !== oldest_byte.last)
                        flag_mismatch("mismatch", oldest_byte, out_data);
                end
            end
            out_ready <= (hold_count == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("rle_lz_token_byte_encoder_top_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every command, every out-of-range case
        set_idle(IDLE_NONE);
        token_queue.push_back(make_token(rlzt_pkg::CMD_LIT_HDR, 1, 0, 0));
        token_queue.push_back(make_token(rlzt_pkg::CMD_LIT_HDR, 31, 8191, 255));
        token_queue.push_back(make_token(rlzt_pkg::CMD_LIT_HDR, 32, 0, 0));
        token_queue.push_back(make_token(rlzt_pkg::CMD_LIT_HDR, 8191, 8191, 255));
        token_queue.push_back(make_token(rlzt_pkg::CMD_LIT_HDR, 0, 0, 0));  // zero length
        token_queue.push_back(make_token(rlzt_pkg::CMD_LITERAL, 0, 0, 8'h00));
        token_queue.push_back(make_token(rlzt_pkg::CMD_LITERAL, 8191, 8191, 8'hFF));
        token_queue.push_back(make_token(rlzt_pkg::CMD_RUN, 4, 0, 8'h5A));
        token_queue.push_back(make_token(rlzt_pkg::CMD_RUN, 19, 0, 8'h01));  // short top
        token_queue.push_back(make_token(rlzt_pkg::CMD_RUN, 20, 0, 8'h80));  // long bottom
        token_queue.push_back(make_token(rlzt_pkg::CMD_RUN, 4099, 8191, 8'hA5));
        token_queue.push_back(make_token(rlzt_pkg::CMD_RUN, 3, 0, 0));       // too short
        token_queue.push_back(make_token(rlzt_pkg::CMD_RUN, 4100, 0, 0));    // too long
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, 4, 1, 0));
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, 7, 8191, 0));  // head only
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, 8, 256, 0));   // one piece
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, MAX_MATCH_LEN, 300, 0));
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, 3, 5, 0));     // too short
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, MAX_MATCH_LEN + 1, 5, 0));
        token_queue.push_back(make_token(rlzt_pkg::CMD_MATCH, 10, 0, 0));    // zero distance
        token_queue.push_back(make_token(CMD_RSVD5, 0, 0, 0));
        token_queue.push_back(make_token(CMD_RSVD6, 8191, 8191, 255));
        token_queue.push_back(make_token(CMD_RSVD7, 40, 40, 40));
        token_queue.push_back(make_token(rlzt_pkg::CMD_FINISH, 0, 0, 0));
        token_queue.push_back(make_token(rlzt_pkg::CMD_FINISH, 8191, 8191, 255));  // empty
        wait_drained();

        // Random phases with different idling on each side
        set_idle(IDLE_SEND);
        add_random_tokens(125);
        wait_drained();

        // Receiver holds off for a long stretch while tokens keep coming
        set_idle(IDLE_RECV);
        add_random_tokens(125);
        hold_req = HOLD_CYCLES;
        wait_drained();

        set_idle(IDLE_BOTH);
        add_random_tokens(125);
        wait_drained();

        set_idle(IDLE_NONE);
        add_random_tokens(125);
        wait_drained();

        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("rle_lz_token_byte_encoder_top_tb: done, clean");
        else
            $display("rle_lz_token_byte_encoder_top_tb: done, errors");
        $finish;
    end

endmodule
